// File: rtl/rti_pkg.sv
// Shared widths, register indexes and defaults for the ray/triangle intersection core.
// No dependencies; used by the core and its checker.
package rti_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 32;               // coordinate width
  localparam int DW = CW + 1;           // difference of two coordinates
  localparam int PPW = 2 * DW;          // one cross-product term
  localparam int QW = PPW + 1;          // cross-product component
  localparam int LOW = 34;              // low slice of a cross component
  localparam int HIW = QW - LOW;        // high slice
  localparam int WW = 104;              // dot products and their sums
  localparam int TW = 31;               // hit distance width
  localparam int DV = WW + TW + 1;      // divider working width
  localparam int TAGW = 16;
  localparam int IN_W = TAGW + 9 * CW;
  localparam int OUT_W = TAGW + 1 + TW + 3 * CW;
  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_EPS   = 3'd6
  } cfg_reg_t;

  localparam logic signed [CW-1:0] DIR_Z_RST = 32'sd65536;
  localparam logic [TW-1:0] EPS_RST = 31'd1;

endpackage

// File: rtl/ray_triangle_intersect_core.sv
// Throughput one item per cycle while the output is not stalled.
// The stage count is set by the 31-stage restoring divider, one quotient bit per stage.
// All stages advance together; the whole pipe stalls only when the output item is not taken.
// Reset (rst, synchronous) clears every valid bit and loads the ray/epsilon reset values.
// Ray/triangle test core. Moller-Trumbore on exact fixed-point numerators.
// Depends on rti_pkg.
module ray_triangle_intersect_core
  import rti_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // tag, v0_x, v0_y, v0_z, v1_x .. v2_z
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // tag_out, hit, hit_distance, hit_x, hit_y, hit_z
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CW-1:0]      cfg_data
);

  localparam int NDIV = TW;
  localparam int NS = 8 + NDIV + 2;
  localparam logic signed [2*CW-1:0] SAT_HI = {{(CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [2*CW-1:0] SAT_LO = {{(CW+1){1'b1}}, {(CW-1){1'b0}}};

  // configuration
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];
  logic [TW-1:0]        eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= '0; dir[1] <= '0; dir[2] <= DIR_Z_RST;
      eps    <= EPS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ORG_X: org[0] <= cfg_data;
        REG_ORG_Y: org[1] <= cfg_data;
        REG_ORG_Z: org[2] <= cfg_data;
        REG_DIR_X: dir[0] <= cfg_data;
        REG_DIR_Y: dir[1] <= cfg_data;
        REG_DIR_Z: dir[2] <= cfg_data;
        REG_EPS:   eps    <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld;
  logic          adv;

  assign adv      = !vld[NS-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], s_tvalid};
    end
  end

  // tag travels alongside every stage
  logic [TAGW-1:0] tag [NS];
  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= s_tdata[TAGW-1:0];
      for (int k = 1; k < NS; k++) tag[k] <= tag[k-1];
    end
  end

  // S1: edges and origin offset
  logic signed [DW-1:0] s1_e1 [3], s1_e2 [3], s1_tv [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s1_e1[c] <= DW'($signed(s_tdata[TAGW + (3+c)*CW +: CW]))
                  - DW'($signed(s_tdata[TAGW + c*CW +: CW]));
        s1_e2[c] <= DW'($signed(s_tdata[TAGW + (6+c)*CW +: CW]))
                  - DW'($signed(s_tdata[TAGW + c*CW +: CW]));
        s1_tv[c] <= DW'(org[c]) - DW'($signed(s_tdata[TAGW + c*CW +: CW]));
      end
    end
  end

  // S2: cross-product terms, pvec = dir x e2, qvec = tvec x e1
  logic signed [PPW-1:0] s2_pa [3], s2_pb [3], s2_qa [3], s2_qb [3];
  logic signed [DW-1:0]  s2_e1 [3], s2_e2 [3], s2_tv [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s2_pa[c] <= DW'(dir[(c+1)%3]) * s1_e2[(c+2)%3];
        s2_pb[c] <= DW'(dir[(c+2)%3]) * s1_e2[(c+1)%3];
        s2_qa[c] <= s1_tv[(c+1)%3] * s1_e1[(c+2)%3];
        s2_qb[c] <= s1_tv[(c+2)%3] * s1_e1[(c+1)%3];
      end
      s2_e1 <= s1_e1; s2_e2 <= s1_e2; s2_tv <= s1_tv;
    end
  end

  // S3: cross components
  logic signed [QW-1:0] s3_p [3], s3_q [3];
  logic signed [DW-1:0] s3_e1 [3], s3_e2 [3], s3_tv [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s3_p[c] <= QW'(s2_pa[c]) - QW'(s2_pb[c]);
        s3_q[c] <= QW'(s2_qa[c]) - QW'(s2_qb[c]);
      end
      s3_e1 <= s2_e1; s3_e2 <= s2_e2; s3_tv <= s2_tv;
    end
  end

  // S4: dot-product partials, each wide term split into a low and a high slice
  // dots: 0 det = e1.p, 1 u = tv.p, 2 v = dir.q, 3 t = e2.q
  logic signed [DW-1:0]      m_a [4][3];
  logic signed [QW-1:0]      m_b [4][3];
  logic signed [DW+LOW:0]    s4_lo [4][3];
  logic signed [DW+HIW-1:0]  s4_hi [4][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      m_a[0][c] = s3_e1[c];   m_b[0][c] = s3_p[c];
      m_a[1][c] = s3_tv[c];   m_b[1][c] = s3_p[c];
      m_a[2][c] = DW'(dir[c]); m_b[2][c] = s3_q[c];
      m_a[3][c] = s3_e2[c];   m_b[3][c] = s3_q[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) begin
        for (int c = 0; c < 3; c++) begin
          s4_lo[d][c] <= m_a[d][c] * $signed({1'b0, m_b[d][c][LOW-1:0]});
          s4_hi[d][c] <= m_a[d][c] * $signed(m_b[d][c][QW-1:LOW]);
        end
      end
    end
  end

  // S5: recombine slices
  logic signed [WW-1:0] s5_pr [4][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) begin
        for (int c = 0; c < 3; c++) begin
          s5_pr[d][c] <= (WW'(s4_hi[d][c]) <<< LOW) + WW'(s4_lo[d][c]);
        end
      end
    end
  end

  // S6: sums
  logic signed [WW-1:0] s6_sum [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) s6_sum[d] <= s5_pr[d][0] + s5_pr[d][1] + s5_pr[d][2];
    end
  end

  // S7: make det non-negative
  logic signed [WW-1:0] s7_det, s7_un, s7_vn, s7_tn;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s6_sum[0][WW-1]) begin
        s7_det <= -s6_sum[0]; s7_un <= -s6_sum[1];
        s7_vn  <= -s6_sum[2]; s7_tn <= -s6_sum[3];
      end else begin
        s7_det <= s6_sum[0]; s7_un <= s6_sum[1];
        s7_vn  <= s6_sum[2]; s7_tn <= s6_sum[3];
      end
    end
  end

  // S8: hit decision, scaled numerator, saturation check
  logic [WW-1:0] eps_sh;
  logic [WW-1:0] uv_sum;
  logic          rej;
  logic [DV-1:0] num_sh;

  assign eps_sh = WW'(eps) << (2 * FRAC_BITS);
  assign uv_sum = WW'(s7_un + s7_vn);
  assign num_sh = DV'(unsigned'(s7_tn)) << FRAC_BITS;
  assign rej = (s7_det == '0) || (unsigned'(s7_det) < eps_sh)
            || s7_un[WW-1] || (unsigned'(s7_det) < unsigned'(s7_un))
            || s7_vn[WW-1] || (unsigned'(s7_det) < uv_sum)
            || s7_tn[WW-1] || (s7_tn == '0);

  logic [DV-1:0] dv_rem [NDIV+1];
  logic [WW-1:0] dv_det [NDIV+1];
  logic [TW-1:0] dv_q   [NDIV+1];
  logic          dv_hit [NDIV+1];
  logic          dv_sat [NDIV+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= num_sh;
      dv_det[0] <= unsigned'(s7_det);
      dv_q[0]   <= '0;
      dv_hit[0] <= !rej;
      dv_sat[0] <= num_sh >= (DV'(unsigned'(s7_det)) << TW);
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int B = NDIV - 1 - k;
    logic [DV-1:0] dsh;
    logic          ge;
    assign dsh = DV'(dv_det[k]) << B;
    assign ge  = dv_rem[k] >= dsh;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k+1] <= ge ? dv_rem[k] - dsh : dv_rem[k];
        dv_q[k+1]   <= dv_q[k] | (ge ? TW'(1) << B : '0);
        dv_det[k+1] <= dv_det[k];
        dv_hit[k+1] <= dv_hit[k];
        dv_sat[k+1] <= dv_sat[k];
      end
    end
  end

  // hit point product
  logic [TW-1:0]          tval, sm_t;
  logic                   sm_hit;
  logic signed [2*CW-1:0] sm_pr [3];

  assign tval = dv_sat[NDIV] ? '1 : dv_q[NDIV];

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_t   <= tval;
      sm_hit <= dv_hit[NDIV];
      for (int c = 0; c < 3; c++) sm_pr[c] <= dir[c] * $signed({1'b0, tval});
    end
  end

  // floor shift, add origin at full width, saturate
  logic signed [2*CW-1:0] sh   [3];
  logic signed [2*CW-1:0] csum [3];
  logic signed [CW-1:0]   coord [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sh[c]   = sm_pr[c] >>> FRAC_BITS;
      csum[c] = sh[c] + (2*CW)'(org[c]);
      if (csum[c] > SAT_HI) begin
        coord[c] = SAT_HI[CW-1:0];
      end else if (csum[c] < SAT_LO) begin
        coord[c] = SAT_LO[CW-1:0];
      end else begin
        coord[c] = csum[c][CW-1:0];
      end
    end
  end

  logic          o_hit;
  logic [TW-1:0] o_t;
  logic [CW-1:0] o_c [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      o_hit <= sm_hit;
      o_t   <= sm_hit ? sm_t : '0;
      for (int c = 0; c < 3; c++) o_c[c] <= sm_hit ? coord[c] : '0;
    end
  end

  assign m_tdata = {o_c[2], o_c[1], o_c[0], o_t, o_hit, tag[NS-1]};

endmodule

// File: rtl/rti_checker.sv
// Port-level checker for the ray/triangle core, bound to the core module.
// Depends on rti_pkg.
module rti_checker
  import rti_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // the pipe moves only when the output stage is empty or drained
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // a miss carries zero distance and zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[TAGW]) |-> (m_tdata[OUT_W-1:TAGW+1] == '0))
    else $error("miss item with non-zero payload");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result item changed");

endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (.*);
